@@ rtl/core/pecs_pkg.sv @@
// Shared widths, constants and types of the pixel exposure/contrast/saturation core.
package pecs_pkg;

   localparam int PixW      = 8;
   localparam int GainW     = 16;
   localparam int FracW     = 16;
   localparam int XW        = PixW + FracW;
   localparam int DevW      = XW + 1;
   localparam int CprodW    = DevW + GainW + 1;
   localparam int YW        = 27;
   localparam int EprodW    = YW + GainW + 1;
   localparam int EW        = 34;
   localparam int LprodW    = EW + GainW + 1;
   localparam int LsumW     = LprodW + 2;
   localparam int DiffW     = EW + 1;
   localparam int SprodW    = DiffW + GainW + 1;
   localparam int SW        = SprodW - 13;
   localparam int Gain14Sh  = 14;
   localparam int ExpSh     = 10;
   localparam int LumaSh    = 16;
   localparam int CsrIdxW   = 2;

   localparam int MidpointQ16 = 8355840;
   localparam int TopQ16      = 255 << FracW;
   localparam int LumaWr      = 13933;
   localparam int LumaWg      = 46871;
   localparam int LumaWb      = 4732;

   localparam logic [CsrIdxW-1:0] RegExposure   = 2'd0;
   localparam logic [CsrIdxW-1:0] RegContrast   = 2'd1;
   localparam logic [CsrIdxW-1:0] RegSaturation = 2'd2;

   localparam logic [GainW-1:0] ExposureReset   = 16'd1024;
   localparam logic [GainW-1:0] ContrastReset   = 16'd16384;
   localparam logic [GainW-1:0] SaturationReset = 16'd16384;

   typedef logic [PixW-1:0]         pix_type;
   typedef logic [GainW-1:0]        gain_type;
   typedef logic signed [EprodW-1:0] eprod_type;
   typedef logic signed [DiffW-1:0]  diff_type;
   typedef logic signed [EW-1:0]     luma_type;

endpackage

@@ rtl/core/pecs_tone.sv @@
// Contrast and exposure multiply stages for one color channel.
module pecs_tone (
   input  logic                clock,
   input  logic                advance,
   input  pecs_pkg::pix_type   chan,
   input  pecs_pkg::gain_type  contrast_gain,
   input  pecs_pkg::gain_type  exposure_gain,
   output pecs_pkg::eprod_type eprod
);

   logic signed [pecs_pkg::DevW-1:0]    dev;
   logic signed [pecs_pkg::GainW:0]     cgain;
   logic signed [pecs_pkg::GainW:0]     egain;
   logic signed [pecs_pkg::CprodW-1:0]  cprod_in;
   logic signed [pecs_pkg::CprodW-1:0]  cprod_ff;
   logic signed [pecs_pkg::YW-1:0]      ylev;
   pecs_pkg::eprod_type                 eprod_in;
   pecs_pkg::eprod_type                 eprod_ff;

   assign cgain = $signed({1'b0, contrast_gain});
   assign egain = $signed({1'b0, exposure_gain});
   assign dev   = $signed({1'b0, chan, {pecs_pkg::FracW{1'b0}}})
                  - pecs_pkg::DevW'(pecs_pkg::MidpointQ16);
   assign cprod_in = pecs_pkg::CprodW'(dev) * pecs_pkg::CprodW'(cgain);
   assign ylev  = pecs_pkg::YW'(cprod_ff >>> pecs_pkg::Gain14Sh)
                  + pecs_pkg::YW'(pecs_pkg::MidpointQ16);
   assign eprod_in = pecs_pkg::EprodW'(ylev) * pecs_pkg::EprodW'(egain);

   always_ff @(posedge clock) begin
      if (advance) begin
         cprod_ff <= cprod_in;
         eprod_ff <= eprod_in;
      end
   end

   assign eprod = eprod_ff;

endmodule

@@ rtl/core/pecs_luma.sv @@
// Luminance weighting and per-channel deviation from luminance.
module pecs_luma (
   input  logic                clock,
   input  logic                advance,
   input  pecs_pkg::eprod_type red_prod,
   input  pecs_pkg::eprod_type green_prod,
   input  pecs_pkg::eprod_type blue_prod,
   output pecs_pkg::luma_type  luma,
   output pecs_pkg::diff_type  red_diff,
   output pecs_pkg::diff_type  green_diff,
   output pecs_pkg::diff_type  blue_diff
);

   localparam logic signed [pecs_pkg::GainW:0] WR = (pecs_pkg::GainW+1)'(pecs_pkg::LumaWr);
   localparam logic signed [pecs_pkg::GainW:0] WG = (pecs_pkg::GainW+1)'(pecs_pkg::LumaWg);
   localparam logic signed [pecs_pkg::GainW:0] WB = (pecs_pkg::GainW+1)'(pecs_pkg::LumaWb);

   pecs_pkg::luma_type                  er, eg, eb;
   pecs_pkg::luma_type                  er_ff, eg_ff, eb_ff;
   logic signed [pecs_pkg::LprodW-1:0]  pr_in, pg_in, pb_in;
   logic signed [pecs_pkg::LprodW-1:0]  pr_ff, pg_ff, pb_ff;
   logic signed [pecs_pkg::LsumW-1:0]   lsum;
   pecs_pkg::luma_type                  luma_in;
   pecs_pkg::luma_type                  luma_ff;
   pecs_pkg::diff_type                  rd_in, gd_in, bd_in;
   pecs_pkg::diff_type                  rd_ff, gd_ff, bd_ff;

   assign er = pecs_pkg::EW'(red_prod   >>> pecs_pkg::ExpSh);
   assign eg = pecs_pkg::EW'(green_prod >>> pecs_pkg::ExpSh);
   assign eb = pecs_pkg::EW'(blue_prod  >>> pecs_pkg::ExpSh);
   assign pr_in = pecs_pkg::LprodW'(er) * pecs_pkg::LprodW'(WR);
   assign pg_in = pecs_pkg::LprodW'(eg) * pecs_pkg::LprodW'(WG);
   assign pb_in = pecs_pkg::LprodW'(eb) * pecs_pkg::LprodW'(WB);

   assign lsum = pecs_pkg::LsumW'(pr_ff) + pecs_pkg::LsumW'(pg_ff) + pecs_pkg::LsumW'(pb_ff);
   assign luma_in = pecs_pkg::EW'(lsum >>> pecs_pkg::LumaSh);
   assign rd_in = pecs_pkg::DiffW'(er_ff) - pecs_pkg::DiffW'(luma_in);
   assign gd_in = pecs_pkg::DiffW'(eg_ff) - pecs_pkg::DiffW'(luma_in);
   assign bd_in = pecs_pkg::DiffW'(eb_ff) - pecs_pkg::DiffW'(luma_in);

   always_ff @(posedge clock) begin
      if (advance) begin
         er_ff   <= er;
         eg_ff   <= eg;
         eb_ff   <= eb;
         pr_ff   <= pr_in;
         pg_ff   <= pg_in;
         pb_ff   <= pb_in;
         luma_ff <= luma_in;
         rd_ff   <= rd_in;
         gd_ff   <= gd_in;
         bd_ff   <= bd_in;
      end
   end

   assign luma       = luma_ff;
   assign red_diff   = rd_ff;
   assign green_diff = gd_ff;
   assign blue_diff  = bd_ff;

endmodule

@@ rtl/core/pecs_finish.sv @@
// Saturation gain, clamp and truncation for one color channel.
module pecs_finish (
   input  logic               clock,
   input  logic               advance,
   input  pecs_pkg::luma_type luma,
   input  pecs_pkg::diff_type diff,
   input  pecs_pkg::gain_type saturation_gain,
   output pecs_pkg::pix_type  chan
);

   logic signed [pecs_pkg::GainW:0]     sgain;
   logic signed [pecs_pkg::SprodW-1:0]  sprod_in;
   logic signed [pecs_pkg::SprodW-1:0]  sprod_ff;
   pecs_pkg::luma_type                  luma_ff;
   logic signed [pecs_pkg::SW-1:0]      sval;
   pecs_pkg::pix_type                   chan_in;
   pecs_pkg::pix_type                   chan_ff;

   assign sgain    = $signed({1'b0, saturation_gain});
   assign sprod_in = pecs_pkg::SprodW'(diff) * pecs_pkg::SprodW'(sgain);
   assign sval     = pecs_pkg::SW'(luma_ff) + pecs_pkg::SW'(sprod_ff >>> pecs_pkg::Gain14Sh);

   always_comb begin
      priority if (sval <= pecs_pkg::SW'(0))
         chan_in = '0;
      else if (sval >= pecs_pkg::SW'(pecs_pkg::TopQ16))
         chan_in = '1;
      else
         chan_in = sval[pecs_pkg::XW-1:pecs_pkg::FracW];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sprod_ff <= sprod_in;
         luma_ff  <= luma;
         chan_ff  <= chan_in;
      end
   end

   assign chan = chan_ff;

endmodule

@@ rtl/core/pixel_exposure_contrast_saturation_core.sv @@
// Top level of the RGBA8 exposure, contrast and saturation pipeline.
//
//   channel  dir  fields (low bit first)
//   req_     in   tdata: red_in, green_in, blue_in, alpha_in
//   rsp_     out  tdata: red_out, green_out, blue_out, alpha_out
//   csr_     in   we, index (0 exposure, 1 contrast, 2 saturation), wdata
//
// One pixel per cycle while the output is not stalled; a pixel passes through the
// six register stages: contrast multiply, exposure multiply, luma weights,
// luma sum and deviation, saturation multiply, clamp.
// The whole pipeline holds while a response waits and rsp_tready is low.
// Synchronous reset empties the pipeline and loads the unity gains.
module pixel_exposure_contrast_saturation_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // red_in, green_in, blue_in, alpha_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // red_out, green_out, blue_out, alpha_out
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int Depth = 6;

   pecs_pkg::gain_type  exp_ff, exp_in;
   pecs_pkg::gain_type  con_ff, con_in;
   pecs_pkg::gain_type  sat_ff, sat_in;
   logic [Depth-1:0]    vld_ff, vld_in;
   pecs_pkg::pix_type   alpha_ff [Depth];
   logic                advance;
   pecs_pkg::eprod_type rp, gp, bp;
   pecs_pkg::luma_type  luma;
   pecs_pkg::diff_type  rd, gd, bd;
   pecs_pkg::pix_type   ro, go, bo;

   assign advance    = !vld_ff[Depth-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = vld_ff[Depth-1];
   assign vld_in     = advance ? {vld_ff[Depth-2:0], req_tvalid} : vld_ff;

   always_comb begin
      exp_in = exp_ff;
      con_in = con_ff;
      sat_in = sat_ff;
      if (csr_we) begin
         unique case (csr_index)
            pecs_pkg::RegExposure:   exp_in = csr_wdata;
            pecs_pkg::RegContrast:   con_in = csr_wdata;
            pecs_pkg::RegSaturation: sat_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         exp_ff <= pecs_pkg::ExposureReset;
         con_ff <= pecs_pkg::ContrastReset;
         sat_ff <= pecs_pkg::SaturationReset;
      end else begin
         vld_ff <= vld_in;
         exp_ff <= exp_in;
         con_ff <= con_in;
         sat_ff <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         alpha_ff[0] <= req_tdata[31:24];
         for (int i = 1; i < Depth; i++) alpha_ff[i] <= alpha_ff[i-1];
      end
   end

   pecs_tone u_tone_r (.clock, .advance, .chan(req_tdata[7:0]),
                       .contrast_gain(con_ff), .exposure_gain(exp_ff), .eprod(rp));
   pecs_tone u_tone_g (.clock, .advance, .chan(req_tdata[15:8]),
                       .contrast_gain(con_ff), .exposure_gain(exp_ff), .eprod(gp));
   pecs_tone u_tone_b (.clock, .advance, .chan(req_tdata[23:16]),
                       .contrast_gain(con_ff), .exposure_gain(exp_ff), .eprod(bp));

   pecs_luma u_luma (.clock, .advance, .red_prod(rp), .green_prod(gp), .blue_prod(bp),
                     .luma, .red_diff(rd), .green_diff(gd), .blue_diff(bd));

   pecs_finish u_fin_r (.clock, .advance, .luma, .diff(rd), .saturation_gain(sat_ff),
                        .chan(ro));
   pecs_finish u_fin_g (.clock, .advance, .luma, .diff(gd), .saturation_gain(sat_ff),
                        .chan(go));
   pecs_finish u_fin_b (.clock, .advance, .luma, .diff(bd), .saturation_gain(sat_ff),
                        .chan(bo));

   assign rsp_tdata = {alpha_ff[Depth-1], bo, go, ro};

endmodule

@@ rtl/core/pecs_checker.sv @@
// Port-level checks on the pixel adjust core, bound to the top level.
module pecs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response transaction changed");

   a_accept_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

   a_accept_when_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request stalled while output drains");

endmodule

bind pixel_exposure_contrast_saturation_core pecs_checker u_pecs_checker (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);

@@ tb/tb_pixel_exposure_contrast_saturation_core.sv @@
// Testbench: random and corner RGBA8 pixels under changing gains, checked against a predictor.
`timescale 1ns / 100ps

module tb_pixel_exposure_contrast_saturation_core;

   localparam logic [pecs_pkg::CsrIdxW-1:0] RegUnused = 2'd3;
   localparam int PixelsPerPhase = 205;
   localparam int NumPhases      = 9;
   localparam int HoldCycles     = 200;
   localparam int TailCycles     = 8;

   typedef struct packed {
      pecs_pkg::pix_type alpha;
      pecs_pkg::pix_type blue;
      pecs_pkg::pix_type green;
      pecs_pkg::pix_type red;
   } rgba_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // red_in, green_in, blue_in, alpha_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // red_out, green_out, blue_out, alpha_out
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;

   pecs_pkg::gain_type expo_gain_q10;
   pecs_pkg::gain_type contrast_gain_q14;
   pecs_pkg::gain_type sat_gain_q14;

   rgba_type pending_pixels[$];
   rgba_type predicted_pixels[$];
   int    mismatch_count = 0;
   int    send_gap_max   = 0;
   int    ready_gap_max  = 0;
   int    send_gap       = 0;
   int    ready_gap      = 0;
   logic  hold_rsp       = 1'b0;
   event  hold_trigger;

   logic [31:0] corner_pixels [11] = '{
      32'h00000000, 32'hFFFFFFFF, 32'h800000FF, 32'h7F00FF00, 32'h01FF0000,
      32'hFE7F7F7F, 32'h55808080, 32'hAA55AA55, 32'h55AA55AA, 32'h0080FE01,
      32'hFF3264C8
   };

   pixel_exposure_contrast_saturation_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic longint tone_q16(pecs_pkg::pix_type c);
      longint x, y;
      x = longint'(c) << pecs_pkg::FracW;
      y = (((x - pecs_pkg::MidpointQ16) * longint'(contrast_gain_q14)) >>> pecs_pkg::Gain14Sh)
          + pecs_pkg::MidpointQ16;
      return (y * longint'(expo_gain_q10)) >>> pecs_pkg::ExpSh;
   endfunction

   function automatic pecs_pkg::pix_type saturate_channel(longint e, longint luma);
      longint s;
      s = luma + (((e - luma) * longint'(sat_gain_q14)) >>> pecs_pkg::Gain14Sh);
      if (s <= 0) return '0;
      if (s >= longint'(pecs_pkg::TopQ16)) return 8'd255;
      return pecs_pkg::pix_type'(s >>> pecs_pkg::FracW);
   endfunction

   function automatic rgba_type adjust_pixel(rgba_type p);
      longint r, g, b, luma;
      rgba_type q;
      r = tone_q16(p.red);
      g = tone_q16(p.green);
      b = tone_q16(p.blue);
      luma = (r * pecs_pkg::LumaWr + g * pecs_pkg::LumaWg + b * pecs_pkg::LumaWb)
             >>> pecs_pkg::LumaSh;
      q.red   = saturate_channel(r, luma);
      q.green = saturate_channel(g, luma);
      q.blue  = saturate_channel(b, luma);
      q.alpha = p.alpha;
      return q;
   endfunction

   function automatic pecs_pkg::pix_type draw_channel();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         2: return pecs_pkg::pix_type'($urandom_range(124, 131));
         default: return pecs_pkg::pix_type'($urandom);
      endcase
   endfunction

   function automatic pecs_pkg::gain_type draw_gain(int lo, int hi, int unity);
      case ($urandom_range(0, 3))
         0: return pecs_pkg::gain_type'($urandom_range(lo, 2 * unity));
         1: return pecs_pkg::gain_type'($urandom);
         default: return pecs_pkg::gain_type'($urandom_range(lo, hi));
      endcase
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      if (mismatch_count < 40)
         $display("%0t: %s got %0d want %0d", $time, field, got, want);
      mismatch_count++;
   endtask

   task automatic write_gain(logic [pecs_pkg::CsrIdxW-1:0] idx, pecs_pkg::gain_type value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         pecs_pkg::RegExposure:   expo_gain_q10     = value;
         pecs_pkg::RegContrast:   contrast_gain_q14 = value;
         pecs_pkg::RegSaturation: sat_gain_q14      = value;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_pixels.size() != 0 || req_tvalid || predicted_pixels.size() != 0)
         @(posedge clock);
      repeat (TailCycles) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            predicted_pixels.push_back(adjust_pixel(rgba_type'(req_tdata)));
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
               req_tdata  <= pending_pixels.pop_front();
               req_tvalid <= 1'b1;
               send_gap = $urandom_range(0, send_gap_max);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rgba_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rgba_type'(rsp_tdata);
            if (predicted_pixels.size() == 0) begin
               report_mismatch("unexpected transaction", int'(rsp_tdata), 0);
            end else begin
               want = predicted_pixels.pop_front();
               if (got.red != want.red)
                  report_mismatch("red_out", int'(got.red), int'(want.red));
               if (got.green != want.green)
                  report_mismatch("green_out", int'(got.green), int'(want.green));
               if (got.blue != want.blue)
                  report_mismatch("blue_out", int'(got.blue), int'(want.blue));
               if (got.alpha != want.alpha)
                  report_mismatch("alpha_out", int'(got.alpha), int'(want.alpha));
            end
            ready_gap = $urandom_range(0, ready_gap_max);
         end
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
         end else if (ready_gap > 0) begin
            ready_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // long receiver stall while the sender keeps going
   initial forever begin
      @(hold_trigger);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HoldCycles) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #1_000_000;
      $display("pixel_exposure_contrast_saturation_core: mismatch");
      $finish;
   end

   initial begin
      rgba_type px;
      expo_gain_q10     = pecs_pkg::ExposureReset;
      contrast_gain_q14 = pecs_pkg::ContrastReset;
      sat_gain_q14      = pecs_pkg::SaturationReset;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < NumPhases; phase++) begin
         wait_idle();
         case (phase)
            0: ;
            1: begin
               write_gain(pecs_pkg::RegExposure, 16'd32);
               write_gain(pecs_pkg::RegContrast, 16'd0);
               write_gain(pecs_pkg::RegSaturation, 16'd0);
            end
            2: begin
               write_gain(pecs_pkg::RegExposure, 16'd32768);
               write_gain(pecs_pkg::RegContrast, 16'd32768);
               write_gain(pecs_pkg::RegSaturation, 16'd32768);
            end
            3: begin
               write_gain(pecs_pkg::RegExposure, 16'hFFFF);
               write_gain(pecs_pkg::RegContrast, 16'hFFFF);
               write_gain(pecs_pkg::RegSaturation, 16'hFFFF);
            end
            4: begin
               write_gain(pecs_pkg::RegExposure, 16'd0);
               write_gain(pecs_pkg::RegContrast, pecs_pkg::ContrastReset);
               write_gain(pecs_pkg::RegSaturation, 16'd32768);
            end
            default: begin
               write_gain(pecs_pkg::RegExposure,
                          draw_gain(32, 32768, pecs_pkg::ExposureReset));
               write_gain(pecs_pkg::RegContrast,
                          draw_gain(0, 32768, pecs_pkg::ContrastReset));
               write_gain(pecs_pkg::RegSaturation,
                          draw_gain(0, 32768, pecs_pkg::SaturationReset));
            end
         endcase
         if (phase != 0)
            write_gain(RegUnused, pecs_pkg::gain_type'($urandom));
         case (phase % 3)
            0: begin send_gap_max = 0; ready_gap_max = 0; end
            1: begin send_gap_max = 9; ready_gap_max = 3; end
            default: begin send_gap_max = 3; ready_gap_max = 9; end
         endcase
         if (phase == 2)
            send_gap_max = 0;
         if (phase == 0 || phase == 3)
            foreach (corner_pixels[k]) pending_pixels.push_back(rgba_type'(corner_pixels[k]));
         for (int n = 0; n < PixelsPerPhase; n++) begin
            if ($urandom_range(0, 4) == 0) begin
               px.red   = draw_channel();
               px.green = pecs_pkg::pix_type'(px.red + $urandom_range(0, 6) - 3);
               px.blue  = pecs_pkg::pix_type'(px.red + $urandom_range(0, 6) - 3);
            end else begin
               px.red   = draw_channel();
               px.green = draw_channel();
               px.blue  = draw_channel();
            end
            px.alpha = pecs_pkg::pix_type'($urandom);
            pending_pixels.push_back(px);
         end
         if (phase == 2) begin
            @(posedge clock);
            -> hold_trigger;
         end
      end
      wait_idle();
      repeat (20) @(posedge clock);
      if (predicted_pixels.size() != 0)
         report_mismatch("missing transactions", 0, predicted_pixels.size());
      if (mismatch_count == 0)
         $display("pixel_exposure_contrast_saturation_core: match");
      else
         $display("pixel_exposure_contrast_saturation_core: mismatch");
      $finish;
   end

endmodule
